/* src/kmst_pkg.sv */
// Shared types and constants for the spanning tree engine.
// No dependencies; imported by every module of the block.
package kmst_pkg;

	localparam int RANK_BITS = 3;
	localparam logic [RANK_BITS-1:0] RANK_MAX = 3'd7;
	localparam logic [5:0] VC_RESET = 6'd26;
	localparam logic REG_VERTEX_COUNT = 1'b0;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SORT_TOP,
		ST_SORT_TOPW,
		ST_SORT_SCAN,
		ST_SORT_SWAP_HI,
		ST_SORT_SWAP_LO,
		ST_FOREST,
		ST_NEXT,
		ST_EDGE_RD,
		ST_EDGE_W,
		ST_FIND_RD,
		ST_FIND_W,
		ST_JOIN,
		ST_JOIN_RANK,
		ST_FINISH
	} kmst_state_t;

endpackage

/* src/kmst_ram.sv */
// Single-port-write, single-port-read synchronous RAM, registered read data.
// Depends on kmst_pkg only by house convention; holds edge and forest stores.
module kmst_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8,
	parameter int AW = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import kmst_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/kruskal_mst_engine_unit.sv */
// Top level of the Kruskal spanning tree engine: load, sort, union-find scan.
// Depends on kmst_pkg and kmst_ram (edge store and parent/rank store).
//
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// edge in   | start, busy          | edge_src, edge_dest, edge_weight, edge_last
// tree out  | tree_valid (strobe)  | tree_src, tree_dest, tree_weight, tree_last,
//           |                      | tree_empty, edges_dropped
// config    | psel, penable, pready| paddr, pwrite, pwdata, prdata
//
// Loading takes one edge per cycle while busy is low. The edge marked last holds
// busy through a selection sort over the n stored edges (one edge store read port),
// then a forest reset over all MAX_VERTICES entries, then a scan of the sorted
// edges with two finds per edge that step up parent links (one forest store port),
// then a finish state.
// Reset clears all control state; the stores need no clearing pass.
// The receiver cannot stall: each result shows for one cycle on tree_valid.
module kruskal_mst_engine_unit #(
	parameter int MAX_VERTICES = 32,
	parameter int MAX_EDGES = 256,
	parameter int WEIGHT_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [4:0]             edge_src,
	input  logic [4:0]             edge_dest,
	input  logic [WEIGHT_BITS-1:0] edge_weight,
	input  logic                   edge_last,
	output logic                   tree_valid,
	output logic [4:0]             tree_src,
	output logic [4:0]             tree_dest,
	output logic [WEIGHT_BITS-1:0] tree_weight,
	output logic                   tree_last,
	output logic                   tree_empty,
	output logic                   edges_dropped,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import kmst_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NVW = $clog2(MAX_VERTICES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int TW = $clog2(MAX_EDGES + 1);
	localparam int EW = 2 * VW + WEIGHT_BITS;
	localparam int FW = VW + RANK_BITS;

	kmst_state_t state_q, state_d;

	logic [5:0]     vc_q;
	logic [NVW-1:0] nv;
	logic [TW-1:0]  total_q, top_q, i_q;
	logic           drop_q;
	logic [AW-1:0]  hi, j_q, best_idx_q, cmp_idx_s1;
	logic           cmp_v_s1;
	logic [EW-1:0]  hi_rec_q, best_rec_q, e_q, pend_q;
	logic           pend_v_q;
	logic [VW-1:0]  k_q, cur_q, ra_q, rb_q;
	logic [RANK_BITS-1:0] rka_q, rkb_q;
	logic           find_b_q;
	logic [NVW-1:0] taken_q;

	logic           accept, store_ok, cfg_wr;
	logic [TW-1:0]  total_nx;

	logic           em_we, em_re;
	logic [AW-1:0]  em_waddr, em_raddr;
	logic [EW-1:0]  em_wdata, em_rdata;
	logic           fm_we, fm_re;
	logic [VW-1:0]  fm_waddr, fm_raddr;
	logic [FW-1:0]  fm_wdata, fm_rdata;

	logic [VW-1:0]        fd_parent;
	logic [RANK_BITS-1:0] fd_rank;
	logic                 stop;
	logic                 rd_gt;

	kmst_ram #(.DEPTH(MAX_EDGES), .WIDTH(EW), .AW(AW)) u_edge_ram (
		.clk(clk), .we(em_we), .waddr(em_waddr), .wdata(em_wdata),
		.re(em_re), .raddr(em_raddr), .rdata(em_rdata)
	);

	kmst_ram #(.DEPTH(MAX_VERTICES), .WIDTH(FW), .AW(VW)) u_forest_ram (
		.clk(clk), .we(fm_we), .waddr(fm_waddr), .wdata(fm_wdata),
		.re(fm_re), .raddr(fm_raddr), .rdata(fm_rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? {26'd0, vc_q} : 32'd0;

	assign nv = (32'(vc_q) > MAX_VERTICES) ? NVW'(MAX_VERTICES) : NVW'(vc_q);
	assign store_ok = (32'(total_q) < MAX_EDGES) && (32'(edge_src) < 32'(nv))
		&& (32'(edge_dest) < 32'(nv));
	assign total_nx = total_q + TW'(store_ok);
	assign hi = AW'(top_q - 1'b1);
	assign fd_parent = fm_rdata[FW-1:RANK_BITS];
	assign fd_rank = fm_rdata[RANK_BITS-1:0];
	assign stop = (nv == '0) || (taken_q == nv - 1'b1) || (i_q == total_q);
	assign rd_gt = em_rdata[WEIGHT_BITS-1:0] > best_rec_q[WEIGHT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		em_we = 1'b0;
		em_waddr = total_q[AW-1:0];
		em_wdata = {VW'(edge_src), VW'(edge_dest), edge_weight};
		em_re = 1'b0;
		em_raddr = hi;
		fm_we = 1'b0;
		fm_waddr = k_q;
		fm_wdata = {k_q, {RANK_BITS{1'b0}}};
		fm_re = 1'b0;
		fm_raddr = cur_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					em_we = store_ok;
					if (edge_last) begin
						state_d = (total_nx > TW'(1)) ? ST_SORT_TOP : ST_FOREST;
					end
				end
			end
			ST_SORT_TOP: begin
				em_re = 1'b1;
				state_d = ST_SORT_TOPW;
			end
			ST_SORT_TOPW: begin
				state_d = ST_SORT_SCAN;
			end
			ST_SORT_SCAN: begin
				em_re = (j_q < hi);
				em_raddr = j_q;
				if (j_q == hi && !cmp_v_s1) begin
					state_d = ST_SORT_SWAP_HI;
				end
			end
			ST_SORT_SWAP_HI: begin
				em_we = (best_idx_q != hi);
				em_waddr = hi;
				em_wdata = best_rec_q;
				state_d = ST_SORT_SWAP_LO;
			end
			ST_SORT_SWAP_LO: begin
				em_we = (best_idx_q != hi);
				em_waddr = best_idx_q;
				em_wdata = hi_rec_q;
				state_d = (top_q > TW'(2)) ? ST_SORT_TOP : ST_FOREST;
			end
			ST_FOREST: begin
				fm_we = 1'b1;
				if (k_q == VW'(MAX_VERTICES - 1)) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				state_d = stop ? ST_FINISH : ST_EDGE_RD;
			end
			ST_EDGE_RD: begin
				em_re = 1'b1;
				em_raddr = i_q[AW-1:0];
				state_d = ST_EDGE_W;
			end
			ST_EDGE_W: begin
				state_d = ST_FIND_RD;
			end
			ST_FIND_RD: begin
				fm_re = 1'b1;
				state_d = ST_FIND_W;
			end
			ST_FIND_W: begin
				if (fd_parent == cur_q && find_b_q) begin
					state_d = ST_JOIN;
				end else begin
					state_d = ST_FIND_RD;
				end
			end
			ST_JOIN: begin
				state_d = ST_NEXT;
				if (ra_q != rb_q) begin
					fm_we = 1'b1;
					if (rka_q < rkb_q) begin
						fm_waddr = ra_q;
						fm_wdata = {rb_q, rka_q};
					end else begin
						fm_waddr = rb_q;
						fm_wdata = {ra_q, rkb_q};
						if (rka_q == rkb_q && rka_q < RANK_MAX) begin
							state_d = ST_JOIN_RANK;
						end
					end
				end
			end
			ST_JOIN_RANK: begin
				fm_we = 1'b1;
				fm_waddr = ra_q;
				fm_wdata = {ra_q, rka_q + 1'b1};
				state_d = ST_NEXT;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q <= VC_RESET;
			total_q <= '0;
			drop_q <= 1'b0;
			top_q <= '0;
			j_q <= '0;
			cmp_v_s1 <= 1'b0;
			k_q <= '0;
			i_q <= '0;
			taken_q <= '0;
			find_b_q <= 1'b0;
			pend_v_q <= 1'b0;
			tree_valid <= 1'b0;
		end else begin
			tree_valid <= 1'b0;
			if (cfg_wr && paddr[2] == REG_VERTEX_COUNT) begin
				vc_q <= pwdata[5:0];
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						total_q <= total_nx;
						drop_q <= drop_q || !store_ok;
						top_q <= total_nx;
						k_q <= '0;
						i_q <= '0;
						taken_q <= '0;
					end
				end
				ST_SORT_TOPW: begin
					j_q <= '0;
					cmp_v_s1 <= 1'b0;
				end
				ST_SORT_SCAN: begin
					cmp_v_s1 <= (j_q < hi);
					if (j_q < hi) begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_SORT_SWAP_LO: begin
					top_q <= top_q - 1'b1;
				end
				ST_FOREST: begin
					k_q <= k_q + 1'b1;
				end
				ST_EDGE_W: begin
					find_b_q <= 1'b0;
				end
				ST_FIND_W: begin
					if (fd_parent == cur_q) begin
						find_b_q <= 1'b1;
					end
				end
				ST_JOIN: begin
					i_q <= i_q + 1'b1;
					if (ra_q != rb_q) begin
						taken_q <= taken_q + 1'b1;
						pend_v_q <= 1'b1;
						tree_valid <= pend_v_q;
					end
				end
				ST_FINISH: begin
					tree_valid <= 1'b1;
					pend_v_q <= 1'b0;
					total_q <= '0;
					drop_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_SORT_TOPW: begin
				hi_rec_q <= em_rdata;
				best_rec_q <= em_rdata;
				best_idx_q <= hi;
			end
			ST_SORT_SCAN: begin
				cmp_idx_s1 <= j_q;
				if (cmp_v_s1 && rd_gt) begin
					best_rec_q <= em_rdata;
					best_idx_q <= cmp_idx_s1;
				end
			end
			ST_EDGE_W: begin
				e_q <= em_rdata;
				cur_q <= em_rdata[EW-1:WEIGHT_BITS+VW];
			end
			ST_FIND_W: begin
				if (fd_parent != cur_q) begin
					cur_q <= fd_parent;
				end else if (!find_b_q) begin
					ra_q <= cur_q;
					rka_q <= fd_rank;
					cur_q <= e_q[WEIGHT_BITS+VW-1:WEIGHT_BITS];
				end else begin
					rb_q <= cur_q;
					rkb_q <= fd_rank;
				end
			end
			ST_JOIN: begin
				if (ra_q != rb_q) begin
					pend_q <= e_q;
					tree_src <= 5'(pend_q[EW-1:WEIGHT_BITS+VW]);
					tree_dest <= 5'(pend_q[WEIGHT_BITS+VW-1:WEIGHT_BITS]);
					tree_weight <= pend_q[WEIGHT_BITS-1:0];
					tree_last <= 1'b0;
					tree_empty <= 1'b0;
					edges_dropped <= drop_q;
				end
			end
			ST_FINISH: begin
				tree_last <= 1'b1;
				edges_dropped <= drop_q;
				if (pend_v_q) begin
					tree_src <= 5'(pend_q[EW-1:WEIGHT_BITS+VW]);
					tree_dest <= 5'(pend_q[WEIGHT_BITS+VW-1:WEIGHT_BITS]);
					tree_weight <= pend_q[WEIGHT_BITS-1:0];
					tree_empty <= 1'b0;
				end else begin
					tree_src <= '0;
					tree_dest <= '0;
					tree_weight <= '0;
					tree_empty <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

/* src/kmst_checker.sv */
// Port-level checks on the spanning tree engine, bound to its top level.
// Depends on kmst_pkg and kruskal_mst_engine_unit.
module kmst_checker #(
	parameter int WEIGHT_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   start,
	input logic                   busy,
	input logic                   tree_valid,
	input logic [4:0]             tree_src,
	input logic [4:0]             tree_dest,
	input logic [WEIGHT_BITS-1:0] tree_weight,
	input logic                   tree_last,
	input logic                   tree_empty,
	input logic                   pready
);
	import kmst_pkg::*;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		tree_valid |=> !tree_valid) else $error("result strobe held two cycles");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		tree_valid && tree_empty |-> tree_last && tree_src == 5'd0 && tree_dest == 5'd0
		&& tree_weight == '0) else $error("empty marker malformed");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		tree_valid |-> (tree_last == !busy)) else $error("final transaction and busy disagree");

	a_busy_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("run began without a transaction");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready dropped");

endmodule

bind kruskal_mst_engine_unit kmst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_kmst_checker (.*);
